// ===== design/consecutive_run_merge_table_defines.svh =====
// assertion macros for the run merge table
`ifndef CONSECUTIVE_RUN_MERGE_TABLE_DEFINES_SVH
`define CONSECUTIVE_RUN_MERGE_TABLE_DEFINES_SVH

// clocked property, disabled during reset
`define CRMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cause in one cycle, effect in the next
`define CRMT_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cause) |=> (effect)) else $error(msg);

`endif

// ===== design/crmt_pkg.sv =====
// shared constants, types and functions of the run merge table
package crmt_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned OUT_LEN_W    = 11;
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLR  = 6'b000010,
    S_RD   = 6'b000100,
    S_CHK  = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    P_SELF  = 5'b00001,
    P_LEFT  = 5'b00010,
    P_RIGHT = 5'b00100,
    P_HI    = 5'b01000,
    P_LO    = 5'b10000
  } phase_e;

  // xor fold, the caller keeps the low index bits
  function automatic logic [KEY_W-1:0] key_hash(input logic [KEY_W-1:0] k);
    return k ^ (k >> 11) ^ (k >> 22);
  endfunction

endpackage

// ===== design/crmt_in_if.sv =====
// input channel: one value word per handshake
interface crmt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

// ===== design/crmt_out_if.sv =====
// output channel: one result word per handshake
interface crmt_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] longest_run;
  logic [10:0] merged_length;
  logic        was_duplicate;
  logic        table_full;

  modport source (output valid, output longest_run, output merged_length,
                  output was_duplicate, output table_full, input ready);
  modport sink   (input valid, input longest_run, input merged_length,
                  input was_duplicate, input table_full, output ready);
endinterface

// ===== design/consecutive_run_merge_table.sv =====
// each hash probe reads a slot in S_RD and checks it in S_CHK, stepping on while the slot
// holds another key; a new value takes a self lookup, a lookup of each neighbor inside the
// key range, one write and up to two end lookups; a duplicate or full drop ends after the
// self lookup. one word at a time: the next word is taken the cycle after the result is
// loaded. reset: control clears at once, then a pass over all 2**clog2(CAPACITY) slots
// empties the table before any word is taken; a restart word runs the same pass first.
`include "consecutive_run_merge_table_defines.svh"

module consecutive_run_merge_table #(
  parameter int unsigned CAPACITY = crmt_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  crmt_in_if.sink           in_i,
  crmt_out_if.source        out_o
);
  import crmt_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned TSIZE = 1 << IDX_W;
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned MEM_W = 1 + KEY_W + LEN_W;

  // table memory: {valid, key, length}
  logic [MEM_W-1:0] mem [TSIZE];
  logic [MEM_W-1:0] rd_q;
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [MEM_W-1:0] wd;

  state_e           st_q, st_d;
  phase_e           ph_q, ph_d;
  logic             init_q, init_d;
  logic [KEY_W-1:0] v_q, v_d, key_q, key_d;
  logic [IDX_W-1:0] idx_q, idx_d, nprb_q, nprb_d, ins_q, ins_d, clr_q, clr_d;
  logic [LEN_W-1:0] l_q, l_d, r_q, r_d, mres_q, mres_d, best_q, best_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             dup_q, dup_d, full_q, full_d;
  logic             ovld_q, ovld_d;
  logic [OUT_LEN_W-1:0] olong_q, olong_d, omerg_q, omerg_d;
  logic             odup_q, odup_d, ofull_q, ofull_d;

  logic             go;
  logic [KEY_W-1:0] go_key;
  phase_e           go_ph;
  logic             rd_vld, hit, done;
  logic [KEY_W-1:0] rd_key;
  logic [LEN_W-1:0] rd_len, merged;
  logic [KEY_W-1:0] hkey;

  function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LEN_W-1:0] x);
    if (32'(x) > 32'(OUT_LEN_MAX)) return OUT_LEN_MAX;
    return OUT_LEN_W'(x);
  endfunction

  assign rd_vld = rd_q[MEM_W-1];
  assign rd_key = rd_q[MEM_W-2 -: KEY_W];
  assign rd_len = rd_q[LEN_W-1:0];
  assign hit    = rd_vld && (rd_key == key_q);
  assign done   = hit || !rd_vld || (&nprb_q);
  assign merged = LEN_W'(l_q + r_q + LEN_W'(1));

  assign in_i.ready          = (st_q == S_IDLE);
  assign out_o.valid         = ovld_q;
  assign out_o.longest_run   = olong_q;
  assign out_o.merged_length = omerg_q;
  assign out_o.was_duplicate = odup_q;
  assign out_o.table_full    = ofull_q;

  always_comb begin
    st_d = st_q; ph_d = ph_q; init_d = init_q;
    v_d = v_q; key_d = key_q; idx_d = idx_q; nprb_d = nprb_q; ins_d = ins_q;
    clr_d = clr_q; l_d = l_q; r_d = r_q; mres_d = mres_q; best_d = best_q;
    cnt_d = cnt_q; dup_d = dup_q; full_d = full_q;
    ovld_d = ovld_q; olong_d = olong_q; omerg_d = omerg_q;
    odup_d = odup_q; ofull_d = ofull_q;
    go = 1'b0; go_key = v_q; go_ph = P_SELF;
    we = 1'b0; wa = idx_q; wd = '0;

    if (ovld_q && out_o.ready) ovld_d = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          v_d = in_i.value;
          l_d = '0; r_d = '0; mres_d = '0; dup_d = 1'b0; full_d = 1'b0;
          if (in_i.restart) begin
            cnt_d = '0; best_d = '0; clr_d = '0; st_d = S_CLR;
          end else begin
            go = 1'b1; go_key = in_i.value; go_ph = P_SELF;
          end
        end
      end
      S_CLR: begin
        we = 1'b1; wa = clr_q; wd = '0;
        clr_d = clr_q + IDX_W'(1);
        if (&clr_q) begin
          if (init_q) begin
            init_d = 1'b0; st_d = S_IDLE;
          end else begin
            go = 1'b1; go_key = v_q; go_ph = P_SELF;
          end
        end
      end
      S_RD: begin
        st_d = S_CHK;
      end
      S_CHK: begin
        if (!done) begin
          idx_d = idx_q + IDX_W'(1); nprb_d = nprb_q + IDX_W'(1); st_d = S_RD;
        end else begin
          case (ph_q)
            P_SELF: begin
              if (hit) begin
                dup_d = 1'b1; st_d = S_OUT;
              end else if (cnt_q >= CNT_W'(CAPACITY)) begin
                full_d = 1'b1; st_d = S_OUT;
              end else begin
                ins_d = idx_q;
                if (v_q != KEY_MIN) begin
                  go = 1'b1; go_key = v_q - 32'd1; go_ph = P_LEFT;
                end else if (v_q != KEY_MAX) begin
                  go = 1'b1; go_key = v_q + 32'd1; go_ph = P_RIGHT;
                end else begin
                  st_d = S_WR;
                end
              end
            end
            P_LEFT: begin
              l_d = hit ? rd_len : '0;
              if (v_q != KEY_MAX) begin
                go = 1'b1; go_key = v_q + 32'd1; go_ph = P_RIGHT;
              end else begin
                st_d = S_WR;
              end
            end
            P_RIGHT: begin
              r_d = hit ? rd_len : '0;
              st_d = S_WR;
            end
            P_HI: begin
              we = 1'b1; wa = idx_q; wd = {1'b1, key_q, mres_q};
              if (l_q != '0) begin
                go = 1'b1; go_key = v_q - KEY_W'(l_q); go_ph = P_LO;
              end else begin
                st_d = S_OUT;
              end
            end
            P_LO: begin
              we = 1'b1; wa = idx_q; wd = {1'b1, key_q, mres_q};
              st_d = S_OUT;
            end
            default: st_d = S_OUT;
          endcase
        end
      end
      S_WR: begin
        // new entry holds the length only if it is a run end
        we = 1'b1; wa = ins_q;
        wd = {1'b1, v_q, ((l_q == '0) || (r_q == '0)) ? merged : LEN_W'(0)};
        mres_d = merged;
        cnt_d  = cnt_q + CNT_W'(1);
        if (merged > best_q) best_d = merged;
        if (r_q != '0) begin
          go = 1'b1; go_key = v_q + KEY_W'(r_q); go_ph = P_HI;
        end else if (l_q != '0) begin
          go = 1'b1; go_key = v_q - KEY_W'(l_q); go_ph = P_LO;
        end else begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d = 1'b1;
          olong_d = sat_len(best_q);
          omerg_d = sat_len(mres_q);
          odup_d = dup_q; ofull_d = full_q;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase

    hkey = key_hash(go_key);
    if (go) begin
      key_d = go_key; idx_d = hkey[IDX_W-1:0]; nprb_d = '0;
      ph_d = go_ph; st_d = S_RD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; ph_q <= P_SELF; init_q <= 1'b1; clr_q <= '0;
      cnt_q <= '0; best_q <= '0; ovld_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; init_q <= init_d; clr_q <= clr_d;
      cnt_q <= cnt_d; best_q <= best_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; key_q <= key_d; idx_q <= idx_d; nprb_q <= nprb_d; ins_q <= ins_d;
    l_q <= l_d; r_q <= r_d; mres_q <= mres_d; dup_q <= dup_d; full_q <= full_d;
    olong_q <= olong_d; omerg_q <= omerg_d; odup_q <= odup_d; ofull_q <= ofull_d;
  end

  `CRMT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `CRMT_ASSERT(a_flags_excl, !(ovld_q && odup_q && ofull_q), "duplicate and full together")
  `CRMT_ASSERT(a_merge_le_best, !ovld_q || (omerg_q <= olong_q), "merged above longest")
  `CRMT_ASSERT_NEXT(a_wr_count, st_q == S_WR, cnt_q == $past(cnt_q) + CNT_W'(1),
    "insert did not bump count")

endmodule

// ===== bench/consecutive_run_merge_table_test.sv =====
// self-checking bench for the consecutive run merge table
`timescale 1ns / 1ps

module consecutive_run_merge_table_test;
  import crmt_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int unsigned IDLE_LIMIT = 60000;
  localparam int          INT_MIN    = 32'sh8000_0000;
  localparam int          INT_MAX    = 32'sh7fff_ffff;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] longest_run;
    logic [OUT_LEN_W-1:0] merged_length;
    logic                 was_duplicate;
    logic                 table_full;
  } run_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  crmt_in_if  in_ch ();
  crmt_out_if out_ch ();

  consecutive_run_merge_table #(.CAPACITY(CAP)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // model of the table: length kept per stored value, meaningful at run ends
  logic [31:0]  run_len [int];
  int unsigned  held_count;
  int unsigned  best_len;
  run_result_t  pending_results [$];
  int unsigned  errors;
  int unsigned  idle_cycles;
  bit           quiet;        // no gaps and no new stalls while set
  int unsigned  stall_left;

  function automatic logic [OUT_LEN_W-1:0] sat(input int unsigned n);
    return (n > OUT_LEN_MAX) ? OUT_LEN_MAX : n[OUT_LEN_W-1:0];
  endfunction

  function automatic run_result_t predict_run(input int v, input bit rs);
    run_result_t r;
    int unsigned left, right, merged;
    left = 0;
    right = 0;
    merged = 0;
    r = '0;
    if (rs) begin
      run_len.delete();
      held_count = 0;
      best_len = 0;
    end
    if (run_len.exists(v)) begin
      r.was_duplicate = 1'b1;
    end else if (held_count >= CAP) begin
      r.table_full = 1'b1;
    end else begin
      // neighbors past the integer limits count as absent
      if (v != INT_MIN && run_len.exists(v - 1)) left = run_len[v - 1];
      if (v != INT_MAX && run_len.exists(v + 1)) right = run_len[v + 1];
      merged = left + 1 + right;
      run_len[v] = 0;
      held_count++;
      run_len[v + int'(right)] = merged;
      run_len[v - int'(left)] = merged;
      if (merged > best_len) best_len = merged;
    end
    r.longest_run = sat(best_len);
    r.merged_length = sat(merged);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input int v, input bit rs);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.restart <= rs;
    // inputs only move at rising edges, so ready seen at the falling edge decides
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    pending_results.push_back(predict_run(v, rs));
  endtask

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) < 3)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
    end
  end

  // result check and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    run_result_t want;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.longest_run !== want.longest_run) begin
            $display("%0t: longest_run expected %0d actual %0d", $realtime,
                     want.longest_run, out_ch.longest_run);
            errors++;
          end
          if (out_ch.merged_length !== want.merged_length) begin
            $display("%0t: merged_length expected %0d actual %0d", $realtime,
                     want.merged_length, out_ch.merged_length);
            errors++;
          end
          if (out_ch.was_duplicate !== want.was_duplicate) begin
            $display("%0t: was_duplicate expected %0b actual %0b", $realtime,
                     want.was_duplicate, out_ch.was_duplicate);
            errors++;
          end
          if (out_ch.table_full !== want.table_full) begin
            $display("%0t: table_full expected %0b actual %0b", $realtime,
                     want.table_full, out_ch.table_full);
            errors++;
          end
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("%0t: no progress", $realtime);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_limits();
    send_word(0, 1'b1);
    send_word(INT_MIN, 1'b0);
    send_word(INT_MAX, 1'b0);     // must not wrap onto the minimum
    send_word(INT_MIN + 1, 1'b0);
    send_word(INT_MAX - 1, 1'b0);
    send_word(INT_MIN, 1'b0);     // duplicate
    send_word(-1, 1'b0);
    send_word(1, 1'b0);           // extends the run of -1 and 0 with 1
    send_word(-2, 1'b0);
    send_word(3, 1'b0);
    send_word(2, 1'b0);           // merges left and right
    send_word(2, 1'b0);
    send_word(-1, 1'b0);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'sh2aaa_aaaa, 1'b0);
    send_word(7, 1'b1);           // restart drops the old runs
    send_word(6, 1'b0);
  endtask

  task automatic test_full_table();
    int base;
    base = $urandom_range(0, 1000000) - 500000;
    for (int i = 0; i < CAP; i++) send_word(base + i, i == 0);
    send_word(base - 1, 1'b0);    // table is full
    send_word(base + CAP, 1'b0);
    send_word(base + 5, 1'b0);    // duplicate still seen
    send_word(base - 3, 1'b1);
  endtask

  task automatic test_random(input int unsigned count);
    int base;
    base = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) quiet = ~quiet;
      if ($urandom_range(0, 9) == 0) base = $urandom();
      if ($urandom_range(0, 9) == 0)
        send_word($urandom(), $urandom_range(0, 40) == 0);
      else
        send_word(base + $urandom_range(0, 40) - 20, $urandom_range(0, 60) == 0);
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.restart <= 1'b0;
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    held_count = 0;
    best_len = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_limits();
    test_full_table();
    test_random(100);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== consecutive_run_merge_table.f =====
+incdir+design
design/crmt_pkg.sv
design/crmt_in_if.sv
design/crmt_out_if.sv
design/consecutive_run_merge_table.sv
bench/consecutive_run_merge_table_test.sv
